// File: design/ldu_smv_pkg.sv
package ldu_smv_pkg;

  localparam int Q_W = 32;
  localparam int FRAC_W = 16;
  localparam int IN_IDX_W = 12;
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] NUM_CELLS_RESET = 13'd4096;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WR_A,
    ST_WR_B
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic up_en;
    logic same_cell;
  } mac_ctl_t;

  function automatic logic signed [Q_W-1:0] sat_prod(input logic signed [2*Q_W-1:0] p);
    logic signed [2*Q_W-FRAC_W-1:0] s;
    s = signed'(p[2*Q_W-1:FRAC_W]);
    if (s[2*Q_W-FRAC_W-1:Q_W-1] == {(Q_W-FRAC_W+1){s[2*Q_W-FRAC_W-1]}}) begin
      return s[Q_W-1:0];
    end
    return s[2*Q_W-FRAC_W-1] ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] == s[Q_W-1]) begin
      return s[Q_W-1:0];
    end
    return s[Q_W] ? Q_MIN : Q_MAX;
  endfunction

endpackage

// File: design/ldu_smv_ram.sv
module ldu_smv_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// File: design/ldu_smv_mac.sv
module ldu_smv_mac (
  input  logic                                    clk,
  input  ldu_smv_pkg::mac_ctl_t                   ctl,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]      coeff_a,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]      coeff_b,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]      x_lo,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]      x_up,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]      r_up,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]      r_lo,
  output logic signed [ldu_smv_pkg::Q_W-1:0]      prod_q,
  output logic signed [ldu_smv_pkg::Q_W-1:0]      up_sum,
  output logic signed [ldu_smv_pkg::Q_W-1:0]      lo_sum
);
  import ldu_smv_pkg::*;

  logic signed [2*Q_W-1:0] prod_a;
  logic signed [2*Q_W-1:0] prod_b;
  logic signed [Q_W-1:0]   up_hold;
  logic signed [Q_W-1:0]   lo_base;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_a <= coeff_a * x_lo;
      prod_b <= coeff_b * x_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.up_en) begin
      up_hold <= up_sum;
    end
  end

  assign prod_q  = sat_prod(prod_a);
  assign up_sum  = sat_add(r_up, prod_q);
  assign lo_base = ctl.same_cell ? up_hold : r_lo;
  assign lo_sum  = sat_add(lo_base, sat_prod(prod_b));

endmodule

// File: design/ldu_sparse_matrix_vector_multiply.sv
// Sparse matrix-vector product over an LDU-form matrix with signed Q16.16 values and
// saturating arithmetic. The vector and result stores are two synchronous RAMs of MAX_CELLS
// words each, one write port and two read ports, with registered reads; their contents are
// undefined after reset until loaded, so there is no clearing pass. One item is in work at a
// time, paced by a sequencer: every item passes the RAM read state, then a load writes the
// result RAM, a read or a flagged index waits for the output register to drain, and a face
// update takes the single write port of the result RAM for the upper-cell and then the
// lower-cell update in turn, after the RAM read and the registered multipliers. Indices at
// or above num_cells (capped at MAX_CELLS) return one beat with index_error set and change
// no store.
module ldu_sparse_matrix_vector_multiply #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ldu_smv_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             opcode,
  input  logic [ldu_smv_pkg::IN_IDX_W-1:0]       cell_index,
  input  logic [ldu_smv_pkg::IN_IDX_W-1:0]       upper_index,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]     coeff_a,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]     coeff_b,
  input  logic signed [ldu_smv_pkg::Q_W-1:0]     x_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ldu_smv_pkg::IN_IDX_W-1:0]       result_index,
  output logic signed [ldu_smv_pkg::Q_W-1:0]     result_value,
  output logic                                   index_error
);
  import ldu_smv_pkg::*;

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_CELLS);

  state_t state, state_next;

  logic [CFG_W-1:0]     num_cells;
  logic [LIM_W-1:0]     limit;
  logic                 error_seen;

  logic [1:0]           op_q;
  logic [IN_IDX_W-1:0]  lo_q;
  logic [IN_IDX_W-1:0]  up_q;
  logic [IN_IDX_W-1:0]  err_idx_q;
  logic                 err_q;
  logic signed [Q_W-1:0] a_q;
  logic signed [Q_W-1:0] b_q;
  logic signed [Q_W-1:0] xv_q;

  logic                 accept;
  logic                 lo_ok;
  logic                 up_ok;
  logic                 in_err;
  logic                 out_free;
  logic                 emit;

  logic [IDX_W-1:0]     rd_lo_addr;
  logic [IDX_W-1:0]     rd_up_addr;
  logic                 vec_we;
  logic signed [Q_W-1:0] vec_lo;
  logic signed [Q_W-1:0] vec_up;
  logic                 res_we;
  logic [IDX_W-1:0]     res_waddr;
  logic signed [Q_W-1:0] res_wdata;
  logic signed [Q_W-1:0] res_lo;
  logic signed [Q_W-1:0] res_up;

  mac_ctl_t             mac_ctl;
  logic signed [Q_W-1:0] mac_x_lo;
  logic signed [Q_W-1:0] prod_q;
  logic signed [Q_W-1:0] up_sum;
  logic signed [Q_W-1:0] lo_sum;

  assign limit  = (LIM_W'(num_cells) > MAX_LIM) ? MAX_LIM : LIM_W'(num_cells);
  assign lo_ok  = LIM_W'(cell_index) < limit;
  assign up_ok  = LIM_W'(upper_index) < limit;
  assign accept = in_valid && in_ready;

  always_comb begin
    unique case (opcode)
      OP_LOAD, OP_READ: in_err = !lo_ok;
      OP_FACE:          in_err = !(lo_ok && up_ok);
      default:          in_err = 1'b0;
    endcase
  end

  assign rd_lo_addr = IDX_W'(cell_index);
  assign rd_up_addr = IDX_W'(upper_index);
  assign vec_we     = accept && (opcode == OP_LOAD) && lo_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells <= NUM_CELLS_RESET;
    end else if (cfg_write) begin
      num_cells <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= opcode;
      lo_q      <= cell_index;
      up_q      <= upper_index;
      err_q     <= in_err;
      err_idx_q <= lo_ok ? upper_index : cell_index;
      a_q       <= coeff_a;
      b_q       <= coeff_b;
      xv_q      <= x_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    emit       = 1'b0;
    res_we     = 1'b0;
    res_waddr  = IDX_W'(lo_q);
    res_wdata  = lo_sum;
    mac_ctl    = '{mul_en: 1'b0, up_en: 1'b0, same_cell: lo_q == up_q};
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mac_ctl.mul_en = 1'b1;
        if (err_q || op_q == OP_READ) begin
          if (out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (op_q == OP_LOAD || op_q == OP_FACE) begin
          state_next = ST_WR_A;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WR_A: begin
        mac_ctl.up_en = 1'b1;
        res_we        = 1'b1;
        if (op_q == OP_LOAD) begin
          res_waddr  = IDX_W'(lo_q);
          res_wdata  = prod_q;
          state_next = ST_IDLE;
        end else begin
          res_waddr  = IDX_W'(up_q);
          res_wdata  = up_sum;
          state_next = ST_WR_B;
        end
      end
      ST_WR_B: begin
        res_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign mac_x_lo = (op_q == OP_LOAD) ? xv_q : vec_lo;

  ldu_smv_ram #(.DEPTH(MAX_CELLS), .WIDTH(Q_W)) u_vec_ram (
    .clk    (clk),
    .we     (vec_we),
    .waddr  (rd_lo_addr),
    .wdata  (x_value),
    .re     (accept),
    .raddr0 (rd_lo_addr),
    .raddr1 (rd_up_addr),
    .rdata0 (vec_lo),
    .rdata1 (vec_up)
  );

  ldu_smv_ram #(.DEPTH(MAX_CELLS), .WIDTH(Q_W)) u_res_ram (
    .clk    (clk),
    .we     (res_we),
    .waddr  (res_waddr),
    .wdata  (res_wdata),
    .re     (accept),
    .raddr0 (rd_lo_addr),
    .raddr1 (rd_up_addr),
    .rdata0 (res_lo),
    .rdata1 (res_up)
  );

  ldu_smv_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .coeff_a (a_q),
    .coeff_b (b_q),
    .x_lo    (mac_x_lo),
    .x_up    (vec_up),
    .r_up    (res_up),
    .r_lo    (res_lo),
    .prod_q  (prod_q),
    .up_sum  (up_sum),
    .lo_sum  (lo_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_index <= err_q ? err_idx_q : lo_q;
      result_value <= err_q ? '0 : res_lo;
      index_error  <= err_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen <= 1'b0;
    end else if (emit && err_q) begin
      error_seen <= 1'b1;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> error_seen)
    else $error("error beat without sticky error flag");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_READ)
    else $error("accepted beat did not start a memory read");

  a_face_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR_B |-> $past(state) == ST_WR_A)
    else $error("lower-cell update without upper-cell update");

  a_good_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !index_error |-> LIM_W'(result_index) < limit)
    else $error("result beat for an out-of-range cell");

endmodule
